### hdl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the bit stream packer: function codes,
// register indexes, controller states and the command, status and result
// bundles passed between the controller, datapath and output stage.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int CAP_W       = 9;
  localparam int TOTAL_W     = 14;
  localparam int WIDX_W      = 8;
  localparam int CNT_W       = 6;
  localparam int FILL_W      = 5;
  localparam int WORD_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CAP_W-1:0] MAX_WORDS = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EN = 2'd1;

  typedef enum logic [2:0] {
    FUNC_RAW    = 3'd0,
    FUNC_VARINT = 3'd1,
    FUNC_RANGED = 3'd2,
    FUNC_MARKER = 3'd3,
    FUNC_FLUSH  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_PUT    = 2'd1,
    OP_VARINT = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic xfer;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_step;
    logic pend_full;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]         n_words;
    logic [WORD_W-1:0]  w0;
    logic [WIDX_W-1:0]  i0;
    logic [WORD_W-1:0]  w1;
    logic [WIDX_W-1:0]  i1;
    logic               ovf;
    logic [TOTAL_W-1:0] bits;
  } result_bundle_t;

endpackage

### hdl/bsp_ctrl.sv
// ----------------------------------------------------------------------------
// bsp_ctrl
// Controller: accepts an item, sequences its execute steps and hands the
// finished results of the previous item to the output stage.
// ----------------------------------------------------------------------------
module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t dp_st,
  input  logic       ob_free,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.xfer  = dp_st.pend_full && ob_free;
        in_tready = !dp_st.pend_full || ob_free;
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.step = 1'b1;
        if (dp_st.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

endmodule

### hdl/bsp_datapath.sv
// ----------------------------------------------------------------------------
// bsp_datapath
// Datapath: configuration registers, operand decode, the bit accumulator
// with capacity checks, and the words gathered for the current item.
// ----------------------------------------------------------------------------
module bsp_datapath
  import bsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            dp_st,
  output result_bundle_t        res
);

  function automatic logic [CNT_W-1:0] bit_len(input logic [WORD_W-1:0] d);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (d[i]) begin
        n = CNT_W'(i + 1);
      end
    end
    return n;
  endfunction

  // configuration
  logic [CAP_W-1:0] cap_cfg_r;
  logic             chk_en_r;
  logic [CAP_W-1:0] cap;

  // item operands
  op_t               op_r,  op_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // packer state
  logic [WORD_W-1:0]  acc_r,   acc_nxt;
  logic [FILL_W-1:0]  fill_r,  fill_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CAP_W-1:0]   nw_r,    nw_nxt;
  logic               ovf_r,   ovf_nxt;

  // words of the current item
  logic [WORD_W-1:0] pw_r  [2];
  logic [WORD_W-1:0] pw_nxt[2];
  logic [WIDX_W-1:0] pi_r  [2];
  logic [WIDX_W-1:0] pi_nxt[2];
  logic [1:0]        pn_r,   pn_nxt;
  logic              pend_r, pend_nxt;

  // decode
  logic [WORD_W-1:0]  dv;
  logic [CNT_W-1:0]   bc;
  logic signed [32:0] sv, smin, smax, diff33, off33;
  logic               rng_ok;
  logic [WORD_W-1:0]  rng_off;
  logic [CNT_W-1:0]   rng_bits;
  op_t                dec_op;
  logic [WORD_W-1:0]  dec_val;
  logic [CNT_W-1:0]   dec_cnt;

  // insertion
  logic [WORD_W-1:0]    put_v, vm;
  logic [CNT_W-1:0]     put_c;
  logic [WORD_W:0]      mask33;
  logic [TOTAL_W:0]     sum_total;
  logic [CNT_W-1:0]     fill_sum;
  logic                 full, slot_out, over_cap;
  logic [2*WORD_W-1:0]  acc_new;
  logic                 push;
  logic [WORD_W-1:0]    push_word;
  logic                 last_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= MAX_WORDS;
      chk_en_r  <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CAPACITY) begin
        cap_cfg_r <= cfg_data;
      end else if (cfg_index == CFG_CHECK_EN) begin
        chk_en_r <= cfg_data[0];
      end
    end
  end

  assign cap = (cap_cfg_r > MAX_WORDS) ? MAX_WORDS : cap_cfg_r;

  // operand decode at accept
  always_comb begin
    dv       = in_tdata[31:0];
    bc       = in_tdata[37:32];
    smin     = {in_tdata[69], in_tdata[69:38]};
    smax     = {in_tdata[101], in_tdata[101:70]};
    sv       = {dv[31], dv};
    diff33   = smax - smin;
    off33    = sv - smin;
    rng_ok   = smax > smin;
    rng_bits = bit_len(diff33[WORD_W-1:0]);
    if (sv < smin) begin
      rng_off = '0;
    end else if (sv > smax) begin
      rng_off = diff33[WORD_W-1:0];
    end else begin
      rng_off = off33[WORD_W-1:0];
    end
    dec_op  = OP_NONE;
    dec_val = dv;
    dec_cnt = bc;
    unique case (func_t'(in_tuser))
      FUNC_RAW: begin
        dec_op = (bc != '0 && bc <= CNT_W'(WORD_W)) ? OP_PUT : OP_NONE;
      end
      FUNC_VARINT: begin
        dec_op = OP_VARINT;
      end
      FUNC_RANGED: begin
        dec_op  = rng_ok ? OP_PUT : OP_NONE;
        dec_val = rng_off;
        dec_cnt = rng_bits;
      end
      FUNC_MARKER: begin
        dec_op  = chk_en_r ? OP_PUT : OP_NONE;
        dec_val = {24'd0, dv[7:0]};
        dec_cnt = CNT_W'(8);
      end
      FUNC_FLUSH: begin
        dec_op = OP_FLUSH;
      end
      default: begin
        dec_op = OP_NONE;
      end
    endcase
  end

  // one insertion per step
  always_comb begin
    if (op_r == OP_VARINT) begin
      put_v = {24'd0, (val_r[31:7] != '0), val_r[6:0]};
      put_c = CNT_W'(8);
    end else begin
      put_v = val_r;
      put_c = cnt_r;
    end
    mask33    = (33'd1 << put_c) - 33'd1;
    vm        = put_v & mask33[WORD_W-1:0];
    sum_total = {1'b0, total_r} + (TOTAL_W+1)'(put_c);
    over_cap  = sum_total > (TOTAL_W+1)'({cap, 5'd0});
    fill_sum  = {1'b0, fill_r} + put_c;
    full      = fill_sum[CNT_W-1];
    slot_out  = nw_r >= cap;
    acc_new   = {32'd0, acc_r} | ({32'd0, vm} << fill_r);
    last_step = (op_r != OP_VARINT) || (val_r[31:7] == '0);
  end

  assign dp_st.last_step = last_step;
  assign dp_st.pend_full = pend_r;

  always_comb begin
    op_nxt    = op_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    nw_nxt    = nw_r;
    ovf_nxt   = ovf_r;
    pw_nxt    = pw_r;
    pi_nxt    = pi_r;
    pn_nxt    = pn_r;
    pend_nxt  = pend_r;
    push      = 1'b0;
    push_word = '0;

    if (cmd.xfer) begin
      pend_nxt = 1'b0;
    end
    if (cmd.load) begin
      op_nxt  = dec_op;
      val_nxt = dec_val;
      cnt_nxt = dec_cnt;
      pn_nxt  = '0;
    end
    if (cmd.step) begin
      unique case (op_r)
        OP_PUT, OP_VARINT: begin
          if (over_cap || (full && slot_out)) begin
            ovf_nxt = 1'b1;
          end else begin
            if (full) begin
              push      = 1'b1;
              push_word = acc_new[WORD_W-1:0];
              acc_nxt   = acc_new[2*WORD_W-1:WORD_W];
            end else begin
              acc_nxt = acc_new[WORD_W-1:0];
            end
            fill_nxt  = fill_sum[FILL_W-1:0];
            total_nxt = sum_total[TOTAL_W-1:0];
          end
        end
        OP_FLUSH: begin
          if (fill_r != '0) begin
            if (slot_out) begin
              ovf_nxt = 1'b1;
            end else begin
              push      = 1'b1;
              push_word = acc_r;
            end
            acc_nxt  = '0;
            fill_nxt = '0;
          end
        end
        OP_NONE: begin
        end
      endcase
      val_nxt = val_r >> 7;
      if (last_step) begin
        pend_nxt = 1'b1;
      end
    end
    if (push) begin
      nw_nxt = nw_r + 1'b1;
      if (!pn_r[1]) begin
        pw_nxt[pn_r[0]] = push_word;
        pi_nxt[pn_r[0]] = nw_r[WIDX_W-1:0];
        pn_nxt          = pn_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_NONE;
      acc_r   <= '0;
      fill_r  <= '0;
      total_r <= '0;
      nw_r    <= '0;
      ovf_r   <= 1'b0;
      pn_r    <= '0;
      pend_r  <= 1'b0;
    end else begin
      op_r    <= op_nxt;
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      nw_r    <= nw_nxt;
      ovf_r   <= ovf_nxt;
      pn_r    <= pn_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    pw_r  <= pw_nxt;
    pi_r  <= pi_nxt;
  end

  assign res.n_words = pn_r;
  assign res.w0      = pw_r[0];
  assign res.i0      = pi_r[0];
  assign res.w1      = pw_r[1];
  assign res.i1      = pi_r[1];
  assign res.ovf     = ovf_r;
  assign res.bits    = total_r;

endmodule

### hdl/bsp_out_stage.sv
// ----------------------------------------------------------------------------
// bsp_out_stage
// Output stage: holds the one or two results of a finished item and
// presents them on the result channel in order.
// ----------------------------------------------------------------------------
module bsp_out_stage
  import bsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   xfer,
  input  result_bundle_t         res,
  output logic                   ob_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]             out_tuser,
  output logic                   out_tlast
);

  logic [1:0]         rc_r, rc_nxt;
  logic               sel_r, sel_nxt;
  logic               wv_r;
  logic [WORD_W-1:0]  w_r [2];
  logic [WIDX_W-1:0]  i_r [2];
  logic               ovf_r;
  logic [TOTAL_W-1:0] bits_r;
  logic [WORD_W-1:0]  word;
  logic [WIDX_W-1:0]  idx;

  assign out_tvalid = rc_r != 2'd0;
  assign ob_free    = (rc_r == 2'd0) || (rc_r == 2'd1 && out_tready);

  always_comb begin
    rc_nxt  = rc_r;
    sel_nxt = sel_r;
    if (xfer) begin
      rc_nxt  = (res.n_words == 2'd0) ? 2'd1 : res.n_words;
      sel_nxt = 1'b0;
    end else if (out_tvalid && out_tready) begin
      rc_nxt  = rc_r - 2'd1;
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r  <= '0;
      sel_r <= 1'b0;
    end else begin
      rc_r  <= rc_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      wv_r   <= res.n_words != 2'd0;
      w_r[0] <= res.w0;
      w_r[1] <= res.w1;
      i_r[0] <= res.i0;
      i_r[1] <= res.i1;
      ovf_r  <= res.ovf;
      bits_r <= res.bits;
    end
  end

  assign word      = wv_r ? w_r[sel_r] : '0;
  assign idx       = wv_r ? i_r[sel_r] : '0;
  assign out_tdata = {1'b0, bits_r, ovf_r, idx, word};
  assign out_tuser = wv_r;
  assign out_tlast = rc_r == 2'd1;

endmodule

### hdl/bit_stream_packer.sv
// ----------------------------------------------------------------------------
// bit_stream_packer
// Packs variable-width fields LSB first into 32-bit words; raw bits, LEB128
// varints, ranged integers, check markers and flush.
// ----------------------------------------------------------------------------
// An item is first accepted and decoded, then the accumulator performs its
// bit-insertion step: a varint takes one insertion step per 8-bit chunk, any
// other item a single step. Each item produces one or two results (a
// status-only result when no word completes); they sit in an output stage
// while the next item is accepted and executed, and an item's results move
// to that stage only once the previous item's results have been taken. The
// user writes configuration through the cfg_ port only while the block is
// idle; the block does not enforce this. Capacity values above 256 words act as 256.
// ----------------------------------------------------------------------------
module bit_stream_packer
  import bsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // cfg_index: 0 capacity_words, 1 check_enable
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // data_value[31:0], bit_count[37:32], range_min[69:38], range_max[101:70]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_word[31:0], word_index[39:32], overflowed[40], bits_written[54:41]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // word_valid[0]
  output logic [0:0]             out_tuser,
  output logic                   out_tlast
);

  ctrl_cmd_t      cmd;
  dp_status_t     dp_st;
  result_bundle_t res;
  logic           ob_free;

  bsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_st     (dp_st),
    .ob_free   (ob_free),
    .cmd       (cmd)
  );

  bsp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .dp_st     (dp_st),
    .res       (res)
  );

  bsp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .xfer       (cmd.xfer),
    .res        (res),
    .ob_free    (ob_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### bench/bit_stream_packer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_stream_packer_checker
// Watches the configuration, input and result channels of the bit stream
// packer, keeps its own copy of the packing state, works out the results of
// every input transaction and compares each result transaction with them.
// ----------------------------------------------------------------------------
module bit_stream_packer_checker
  import bsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     mismatches,
  output int                     results_pending,
  output int                     packed_bits,
  output int                     packed_words,
  output int                     items_seen,
  output int                     results_seen,
  output int                     words_seen
);

  typedef struct packed {
    logic               word_valid;
    logic [WORD_W-1:0]  word;
    logic [WIDX_W-1:0]  index;
    logic               overflowed;
    logic [TOTAL_W-1:0] bits;
    logic               last;
  } packer_result_t;

  packer_result_t    packer_results_q[$];
  logic [WORD_W-1:0] done_words[$];
  logic [WIDX_W-1:0] done_index[$];

  logic [63:0]      acc = '0;
  int unsigned      fill = 0;
  int unsigned      total = 0;
  int unsigned      next_slot = 0;
  logic             ovf = 1'b0;
  logic [CAP_W-1:0] capacity = MAX_WORDS;
  logic             check_en = 1'b0;

  initial begin
    mismatches      = 0;
    results_pending = 0;
    packed_bits     = 0;
    packed_words    = 0;
    items_seen      = 0;
    results_seen    = 0;
    words_seen      = 0;
  end

  function automatic int unsigned slot_limit();
    return (capacity < MAX_WORDS) ? int'(capacity) : int'(MAX_WORDS);
  endfunction

  task automatic emit_word(input logic [WORD_W-1:0] w);
    if (done_words.size() < 2) begin
      done_words.push_back(w);
      done_index.push_back(WIDX_W'(next_slot));
    end
    next_slot++;
  endtask

  task automatic pack_bits(input logic [31:0] value, input int unsigned count);
    int unsigned lim;
    logic [31:0] masked;
    if (count == 0 || count > 32) return;
    lim = slot_limit();
    if (total + count > lim * 32) begin
      ovf = 1'b1;
      return;
    end
    if (fill + count >= 32 && next_slot >= lim) begin
      ovf = 1'b1;
      return;
    end
    masked = (count < 32) ? (value & ((32'd1 << count) - 32'd1)) : value;
    acc = acc | ({32'd0, masked} << fill);
    fill = fill + count;
    if (fill >= 32) begin
      emit_word(acc[31:0]);
      acc = acc >> 32;
      fill = fill - 32;
    end
    total = total + count;
  endtask

  task automatic pack_varint(input logic [31:0] value);
    logic [31:0] rest;
    logic [7:0] chunk;
    rest = value;
    for (int i = 0; i < 5; i++) begin
      chunk = {1'b0, rest[6:0]};
      rest = rest >> 7;
      if (rest != 0) chunk[7] = 1'b1;
      pack_bits({24'd0, chunk}, 8);
      if (rest == 0) break;
    end
  endtask

  task automatic pack_ranged(input logic [31:0] value, input logic [31:0] lo,
                             input logic [31:0] hi);
    longint v, vmin, vmax, span;
    int unsigned width;
    v    = longint'($signed(value));
    vmin = longint'($signed(lo));
    vmax = longint'($signed(hi));
    if (vmax <= vmin) return;
    span  = vmax - vmin;
    width = 0;
    while (width < 32 && (span >> width) != 0) width++;
    if (v < vmin) v = vmin;
    if (v > vmax) v = vmax;
    pack_bits(32'(v - vmin), width);
  endtask

  task automatic flush_partial();
    if (fill == 0) return;
    if (next_slot >= slot_limit()) ovf = 1'b1;
    else emit_word(acc[31:0]);
    acc  = '0;
    fill = 0;
  endtask

  task automatic note_mismatch(input string what, input packer_result_t want,
                               input packer_result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): expected vld=%0d word=%h idx=%0d ovf=%0d bits=%0d last=%0d",
               $time, what, want.word_valid, want.word, want.index, want.overflowed,
               want.bits, want.last);
      $display("%0t                 actual   vld=%0d word=%h idx=%0d ovf=%0d bits=%0d last=%0d",
               $time, seen.word_valid, seen.word, seen.index, seen.overflowed,
               seen.bits, seen.last);
    end
  endtask

  always @(posedge clk) begin
    packer_result_t want;
    packer_result_t seen;
    int n;
    if (!rst_n) begin
      acc       = '0;
      fill      = 0;
      total     = 0;
      next_slot = 0;
      ovf       = 1'b0;
      capacity  = MAX_WORDS;
      check_en  = 1'b0;
      packer_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAPACITY) capacity = cfg_data;
        else if (cfg_index == CFG_CHECK_EN) check_en = cfg_data[0];
      end
      if (in_tvalid && in_tready) begin
        done_words.delete();
        done_index.delete();
        items_seen++;
        case (in_tuser)
          FUNC_RAW:    pack_bits(in_tdata[31:0], in_tdata[37:32]);
          FUNC_VARINT: pack_varint(in_tdata[31:0]);
          FUNC_RANGED: pack_ranged(in_tdata[31:0], in_tdata[69:38], in_tdata[101:70]);
          FUNC_MARKER: if (check_en) pack_bits({24'd0, in_tdata[7:0]}, 8);
          FUNC_FLUSH:  flush_partial();
          default: ;
        endcase
        n = (done_words.size() > 0) ? done_words.size() : 1;
        for (int k = 0; k < n; k++) begin
          want = '0;
          if (done_words.size() > 0) begin
            want.word_valid = 1'b1;
            want.word       = done_words[k];
            want.index      = done_index[k];
          end
          want.overflowed = ovf;
          want.bits       = TOTAL_W'(total);
          want.last       = (k == n - 1);
          packer_results_q.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        seen = {out_tuser[0], out_tdata[31:0], out_tdata[39:32], out_tdata[40],
                out_tdata[54:41], out_tlast};
        if (packer_results_q.size() == 0) begin
          note_mismatch("no result expected", '0, seen);
        end else begin
          want = packer_results_q.pop_front();
          if (seen.word_valid) words_seen++;
          if (seen !== want) note_mismatch("field differs", want, seen);
        end
      end
      results_pending = packer_results_q.size();
      packed_bits     = total;
      packed_words    = next_slot;
    end
  end

endmodule

### bench/bit_stream_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_stream_packer_tb
// Drives the bit stream packer with directed and random raw, varint, ranged,
// marker and flush items in bursts, stalls the result side, walks the
// capacity and marker settings through their extremes and reports the
// verdict from the checker's mismatch and pending-result counts.
// ----------------------------------------------------------------------------
module bit_stream_packer_tb;
  import bsp_pkg::*;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;

  int mismatches, results_pending, packed_bits, packed_words;
  int items_seen, results_seen, words_seen;
  int burst_left = 0;
  int cfg_writes = 0;

  stall_mode_t stall_mode = STALL_NONE;
  logic [4:0]  stall_phase = '0;
  logic [15:0] stall_pat = '1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bit_stream_packer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bit_stream_packer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .results_pending (results_pending),
    .packed_bits     (packed_bits),
    .packed_words    (packed_words),
    .items_seen      (items_seen),
    .results_seen    (results_seen),
    .words_seen      (words_seen)
  );

  always @(negedge clk) begin
    stall_phase <= stall_phase + 5'd1;
    if (stall_phase == '0) begin
      stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_PATTERN));
      stall_pat  <= 16'($urandom);
    end
    case (stall_mode)
      STALL_NONE:   out_tready <= 1'b1;
      STALL_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default:      out_tready <= stall_pat[stall_phase[3:0]];
    endcase
  end

  task automatic send_item(input logic [2:0] f, input logic [31:0] value,
                           input logic [5:0] count, input logic [31:0] lo,
                           input logic [31:0] hi);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {2'b00, hi, lo, count, value};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random(input bit heavy);
    int pick, sel;
    logic [31:0] value, lo, hi, span;
    logic [5:0] count;
    logic [2:0] f;
    value = $urandom;
    lo    = $urandom;
    hi    = $urandom;
    count = 6'($urandom_range(1, 8));
    pick  = $urandom_range(0, 99);
    sel   = $urandom_range(0, 9);
    if (pick < 40) begin
      f = FUNC_RAW;
      if (sel == 0) count = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
      else if (sel == 1) count = 6'd32;
      else if (sel < 4) count = 6'($urandom_range(9, 31));
    end else if (pick < 60) begin
      f = FUNC_VARINT;
      value = $urandom >> $urandom_range(heavy ? 0 : 8, 31);
    end else if (pick < 80) begin
      f = FUNC_RANGED;
      span = $urandom >> $urandom_range(heavy ? 0 : 18, 31);
      if (sel == 1) hi = lo - span;
      else if (sel > 1) hi = lo + span;
      if ($urandom_range(0, 1) == 0) value = lo + ($urandom & span);
    end else if (pick < 90) begin
      f = FUNC_MARKER;
    end else if (pick < 95) begin
      f = FUNC_FLUSH;
    end else if (pick < 97) begin
      f = 3'(FUNC_FLUSH + $urandom_range(1, 3));
    end else begin
      f = FUNC_RAW;
      count = 6'd0;
    end
    send_item(f, value, count, lo, hi);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  task automatic run_random(input int n, input bit heavy);
    repeat (n) send_random(heavy);
    settle();
  endtask

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", results_pending);
    $display("[bit_stream_packer] ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // raw extremes and ignored counts
    send_item(FUNC_RAW, 32'h0000_0001, 6'd1, 32'h0, 32'h0);
    send_item(FUNC_RAW, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_RAW, 32'hFFFF_FFFF, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_RAW, 32'hFFFF_FFFF, 6'd33, 32'h0, 32'h0);
    send_item(FUNC_RAW, 32'hFFFF_FFFF, 6'd63, 32'h0, 32'h0);
    // varint chunk boundaries, then a five-chunk varint over a nearly full word
    send_item(FUNC_VARINT, 32'd0, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_VARINT, 32'd127, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_VARINT, 32'd128, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_RAW, 32'hA5A5_A5A5, 6'd30, 32'h0, 32'h0);
    send_item(FUNC_VARINT, 32'hFFFF_FFFF, 6'd0, 32'h0, 32'h0);
    // marker while disabled
    send_item(FUNC_MARKER, 32'hFFFF_FF5A, 6'd8, 32'h0, 32'h0);
    // ranged: empty ranges, full range, clamp low and high
    send_item(FUNC_RANGED, 32'd5, 6'd0, 32'd5, 32'd5);
    send_item(FUNC_RANGED, 32'd0, 6'd0, 32'd100, -32'sd100);
    send_item(FUNC_RANGED, 32'h8000_0000, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(FUNC_RANGED, -32'sd50, 6'd0, -32'sd10, 32'sd10);
    send_item(FUNC_RANGED, 32'sd1000, 6'd0, -32'sd10, 32'sd10);
    // unused function codes
    send_item(3'(FUNC_FLUSH + 1), 32'hFFFF_FFFF, 6'd8, 32'h0, 32'h0);
    send_item(3'(FUNC_FLUSH + 2), 32'hFFFF_FFFF, 6'd8, 32'h0, 32'h0);
    send_item(3'(FUNC_FLUSH + 3), 32'hFFFF_FFFF, 6'd8, 32'h0, 32'h0);
    // flush a partial word, then flush an empty one
    send_item(FUNC_FLUSH, 32'h0, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_FLUSH, 32'h0, 6'd0, 32'h0, 32'h0);
    settle();

    write_reg(CFG_CHECK_EN, 1);
    send_item(FUNC_MARKER, 32'hFFFF_FFA5, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_MARKER, 32'h0000_00FF, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_MARKER, 32'h1234_5600, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_FLUSH, 32'h0, 6'd0, 32'h0, 32'h0);
    settle();

    write_reg(CFG_CAPACITY, 511);
    write_reg(CFG_CHECK_EN, $urandom_range(0, 1));
    run_random(130, 1'b0);
    write_reg(CFG_CAPACITY, 256);
    write_reg(CFG_CHECK_EN, 0);
    run_random(130, 1'b0);
    write_reg(CFG_CAPACITY, 300);
    write_reg(CFG_CHECK_EN, 1);
    run_random(130, 1'b0);

    // word slot edge: capacity ends at the next free slot
    send_item(FUNC_RAW, $urandom, 6'd5, 32'h0, 32'h0);
    send_item(FUNC_FLUSH, 32'h0, 6'd0, 32'h0, 32'h0);
    settle();
    write_reg(CFG_CAPACITY, packed_words);
    run_random(15, 1'b0);
    send_item(FUNC_FLUSH, 32'h0, 6'd0, 32'h0, 32'h0);
    settle();

    // bit capacity edge with long varints
    write_reg(CFG_CAPACITY, packed_bits / 32 + 2);
    run_random(40, 1'b1);

    write_reg(CFG_CAPACITY, 0);
    write_reg(CFG_CHECK_EN, 0);
    run_random(15, 1'b0);

    write_reg(CFG_CAPACITY, 511);
    write_reg(CFG_CHECK_EN, 1);
    run_random(50, 1'b0);

    $display("Covered %0d items and %0d results (%0d packed words) over %0d register writes",
             items_seen, results_seen, words_seen, cfg_writes);
    $display("Stream ended at %0d accepted bits in %0d word slots, %0d mismatches",
             packed_bits, packed_words, mismatches);
    if (mismatches == 0 && results_pending == 0) begin
      $display("[bit_stream_packer] OK");
    end else begin
      $display("[bit_stream_packer] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bsp_pkg.sv
hdl/bsp_ctrl.sv
hdl/bsp_datapath.sv
hdl/bsp_out_stage.sv
hdl/bit_stream_packer.sv
bench/bit_stream_packer_checker.sv
bench/bit_stream_packer_tb.sv
